// File: hdl/cntbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntbl_pkg
// Shared types and codes for the compacting node table.
// ----------------------------------------------------------------------------
package cntbl_pkg;

    localparam int KIND_W    = 3;
    localparam int ADDR_W    = 7;
    localparam int ID_W      = 8;
    localparam int CODE_W    = 16;
    localparam int STAT_W    = 2;
    localparam int FID_W     = 4;
    localparam int CNT_OUT_W = 5;

    localparam logic [KIND_W-1:0] KIND_ADD       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIND_ID   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FIND_ADDR = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REMOVE    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR     = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_DUP      = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

    localparam logic [CNT_OUT_W-1:0] NODE_LIMIT_RST = 5'd16;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] vendor;
        logic [CODE_W-1:0] product;
    } entry_t;

    typedef struct packed {
        logic            rotate;
        logic            compact;
        logic [ID_W-1:0] rm_id;
    } cell_ctrl_t;

endpackage

// File: hdl/cntbl_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntbl_cell
// One table entry; loads its neighbor's entry on a rotate or a compaction.
// ----------------------------------------------------------------------------
module cntbl_cell #(
    parameter int IDX = 0
) (
    input  logic                  clk,
    input  cntbl_pkg::cell_ctrl_t ctrl,
    input  cntbl_pkg::entry_t     nxt,
    output cntbl_pkg::entry_t     cur
);

    localparam logic [cntbl_pkg::ID_W-1:0] IDX_V = IDX[cntbl_pkg::ID_W-1:0];

    cntbl_pkg::entry_t entry_reg;
    logic              load;

    // compaction: every cell at or above the removed id takes its neighbor
    assign load = ctrl.rotate || (ctrl.compact && (IDX_V >= ctrl.rm_id));

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= nxt;
        end
    end

    assign cur = entry_reg;

endmodule

// File: hdl/compacting_node_table_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_node_table_core
// Dense node table built as a ring of entry cells with an append count.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  --------+-------------------------------------------+-----
//  in      | in_valid/in_ready, kind, address, node_id,| in
//          | vendor_code, product_code                 |
//  out     | out_valid/out_ready, status, found_id,    | out
//          | found_address, found_vendor,              |
//          | found_product, entry_count                |
//  cfg     | cfg_valid/cfg_ready, cfg_data (node limit)| in
//
//  Add and both finds rotate the ring once per beat.
//  Remove, clear and early rejects skip the scan; remove compacts all at once.
//  One beat in flight; out register lets the next beat in while a result waits.
//  Reset: count 0, node limit 16; entry contents are not cleared.
//  cfg_ready is always high.
// ----------------------------------------------------------------------------
module compacting_node_table_core #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  kind,
    input  logic [6:0]  address,
    input  logic [7:0]  node_id,
    input  logic [15:0] vendor_code,
    input  logic [15:0] product_code,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [3:0]  found_id,
    output logic [6:0]  found_address,
    output logic [15:0] found_vendor,
    output logic [15:0] found_product,
    output logic [4:0]  entry_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W     = (CNT_W > cntbl_pkg::CNT_OUT_W) ? CNT_W : cntbl_pkg::CNT_OUT_W;
    localparam int ID_W      = cntbl_pkg::ID_W;
    localparam int FID_W     = cntbl_pkg::FID_W;
    localparam int CNT_OUT_W = cntbl_pkg::CNT_OUT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [CNT_OUT_W-1:0]             node_limit_reg, node_limit_next;
    logic                             out_valid_reg, out_valid_next;

    logic [IDX_W-1:0]                 step_reg, step_next;
    logic                             hit_reg, hit_next;
    logic [cntbl_pkg::KIND_W-1:0]     kind_reg, kind_next;
    logic [ID_W-1:0]                  id_reg, id_next;
    cntbl_pkg::entry_t                key_reg, key_next;
    logic [cntbl_pkg::STAT_W-1:0]     res_status_reg, res_status_next;
    logic [FID_W-1:0]                 res_id_reg, res_id_next;
    cntbl_pkg::entry_t                res_entry_reg, res_entry_next;
    logic [cntbl_pkg::STAT_W-1:0]     out_status_reg, out_status_next;
    logic [FID_W-1:0]                 out_id_reg, out_id_next;
    cntbl_pkg::entry_t                out_entry_reg, out_entry_next;
    logic [CNT_OUT_W-1:0]             out_count_reg, out_count_next;

    cntbl_pkg::entry_t                cell_q [TABLE_DEPTH];
    cntbl_pkg::entry_t                head;
    cntbl_pkg::entry_t                tail_in;
    cntbl_pkg::cell_ctrl_t            ctrl;

    logic accept;
    logic table_full;
    logic id_valid;
    logic in_range;
    logic last_step;
    logic addr_match;
    logic write_new;

    assign accept     = in_valid && in_ready;
    assign table_full = (LIM_W'(count_reg) >= LIM_W'(node_limit_reg))
                        || (count_reg == CNT_W'(TABLE_DEPTH));
    assign id_valid   = node_id < ID_W'(count_reg);
    assign head       = cell_q[0];
    assign in_range   = CNT_W'(step_reg) < count_reg;
    assign last_step  = step_reg == IDX_W'(TABLE_DEPTH - 1);
    assign addr_match = head.addr == key_reg.addr;
    assign write_new  = (state_reg == S_SCAN) && (kind_reg == cntbl_pkg::KIND_ADD)
                        && (CNT_W'(step_reg) == count_reg)
                        && (res_status_reg == cntbl_pkg::STAT_OK);
    assign tail_in    = write_new ? key_reg : head;

    assign ctrl.rotate  = state_reg == S_SCAN;
    assign ctrl.compact = accept && (kind == cntbl_pkg::KIND_REMOVE) && id_valid;
    assign ctrl.rm_id   = node_id;

    // ring: each cell takes its right neighbor, the last takes the head or a new entry
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        cntbl_pkg::entry_t nxt;
        if (i == TABLE_DEPTH - 1)
        begin : g_tail
            assign nxt = tail_in;
        end
        else
        begin : g_body
            assign nxt = cell_q[i + 1];
        end
        cntbl_cell #(
            .IDX(i)
        ) u_cell (
            .clk  (clk),
            .ctrl (ctrl),
            .nxt  (nxt),
            .cur  (cell_q[i])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        node_limit_next = node_limit_reg;
        out_valid_next  = out_valid_reg;
        step_next       = step_reg;
        hit_next        = hit_reg;
        kind_next       = kind_reg;
        id_next         = id_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_entry_next  = res_entry_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_entry_next  = out_entry_reg;
        out_count_next  = out_count_reg;

        if (cfg_valid)
        begin
            node_limit_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    kind_next      = kind;
                    id_next        = node_id;
                    key_next       = '{addr: address, vendor: vendor_code,
                                       product: product_code};
                    step_next      = '0;
                    hit_next       = 1'b0;
                    res_id_next    = '0;
                    res_entry_next = '0;
                    state_next     = S_DONE;
                    unique case (kind)
                        cntbl_pkg::KIND_ADD:
                        begin
                            if (table_full)
                            begin
                                res_status_next = cntbl_pkg::STAT_FULL;
                            end
                            else
                            begin
                                res_status_next = cntbl_pkg::STAT_OK;
                                res_id_next     = FID_W'(count_reg);
                                state_next      = S_SCAN;
                            end
                        end
                        cntbl_pkg::KIND_FIND_ID:
                        begin
                            res_status_next = cntbl_pkg::STAT_NOTFOUND;
                            if (id_valid)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        cntbl_pkg::KIND_FIND_ADDR:
                        begin
                            res_status_next = cntbl_pkg::STAT_NOTFOUND;
                            if (count_reg != '0)
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        cntbl_pkg::KIND_REMOVE:
                        begin
                            if (id_valid)
                            begin
                                res_status_next = cntbl_pkg::STAT_OK;
                                count_next      = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                res_status_next = cntbl_pkg::STAT_NOTFOUND;
                            end
                        end
                        cntbl_pkg::KIND_CLEAR:
                        begin
                            res_status_next = cntbl_pkg::STAT_OK;
                            count_next      = '0;
                        end
                        default:
                        begin
                            res_status_next = cntbl_pkg::STAT_NOTFOUND;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                step_next = step_reg + IDX_W'(1);
                unique case (kind_reg)
                    cntbl_pkg::KIND_ADD:
                    begin
                        if (in_range && addr_match)
                        begin
                            res_status_next = cntbl_pkg::STAT_DUP;
                            res_id_next     = '0;
                        end
                    end
                    cntbl_pkg::KIND_FIND_ID:
                    begin
                        if (ID_W'(step_reg) == id_reg)
                        begin
                            res_status_next = cntbl_pkg::STAT_OK;
                            res_id_next     = FID_W'(step_reg);
                            res_entry_next  = head;
                        end
                    end
                    cntbl_pkg::KIND_FIND_ADDR:
                    begin
                        if (!hit_reg && in_range && addr_match)
                        begin
                            hit_next        = 1'b1;
                            res_status_next = cntbl_pkg::STAT_OK;
                            res_id_next     = FID_W'(step_reg);
                            res_entry_next  = head;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (last_step)
                begin
                    state_next = S_DONE;
                    // duplicates are seen below the count, so before the last step
                    if ((kind_reg == cntbl_pkg::KIND_ADD)
                        && (res_status_reg == cntbl_pkg::STAT_OK))
                    begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_entry_next  = res_entry_reg;
                    out_count_next  = CNT_OUT_W'(count_reg);
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            node_limit_reg <= cntbl_pkg::NODE_LIMIT_RST;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            node_limit_reg <= node_limit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg       <= step_next;
        hit_reg        <= hit_next;
        kind_reg       <= kind_next;
        id_reg         <= id_next;
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_entry_reg  <= res_entry_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_entry_reg  <= out_entry_next;
        out_count_reg  <= out_count_next;
    end

    assign in_ready      = state_reg == S_IDLE;
    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found_id      = out_id_reg;
    assign found_address = out_entry_reg.addr;
    assign found_vendor  = out_entry_reg.vendor;
    assign found_product = out_entry_reg.product;
    assign entry_count   = out_count_reg;

endmodule

// File: hdl/cntbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cntbl_checker
// Port-level checks for the compacting node table, bound to the top level.
// ----------------------------------------------------------------------------
module cntbl_checker #(
    parameter int TABLE_DEPTH = 16
) (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic [1:0]  status,
    input logic [3:0]  found_id,
    input logic [6:0]  found_address,
    input logic [15:0] found_vendor,
    input logic [15:0] found_product,
    input logic [4:0]  entry_count
);

    localparam int CNT_MAX = (TABLE_DEPTH < 31) ? TABLE_DEPTH : 31;

    // one beat in flight
    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while a beat is in flight");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(entry_count) <= 32'(CNT_MAX)))
        else $error("entry count beyond table depth");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ((status == cntbl_pkg::STAT_DUP) || (status == cntbl_pkg::STAT_FULL)))
        |-> ((found_id == '0) && (found_address == '0)
             && (found_vendor == '0) && (found_product == '0)))
        else $error("rejected add carries entry data");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == cntbl_pkg::STAT_NOTFOUND))
        |-> ((found_id == '0) && (found_address == '0)
             && (found_vendor == '0) && (found_product == '0)))
        else $error("miss carries entry data");

endmodule

bind compacting_node_table_core cntbl_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
) u_cntbl_checker (.*);

// File: tb/compacting_node_table_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compacting_node_table_core_tb
// Sends add, find, remove and clear traffic with random gaps and output
// stalls, and changes the node limit between phases while the table is idle.
// A shadow table predicts every reply, and each reply is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [cntbl_pkg::STAT_W-1:0]    status;
    logic [cntbl_pkg::FID_W-1:0]     id;
    logic [cntbl_pkg::ADDR_W-1:0]    addr;
    logic [cntbl_pkg::CODE_W-1:0]    vendor;
    logic [cntbl_pkg::CODE_W-1:0]    product;
    logic [cntbl_pkg::CNT_OUT_W-1:0] count;
} node_reply_t;

class node_table_model #(int SLOTS = 16);
    logic [cntbl_pkg::ADDR_W-1:0] slot_addr    [SLOTS];
    logic [cntbl_pkg::CODE_W-1:0] slot_vendor  [SLOTS];
    logic [cntbl_pkg::CODE_W-1:0] slot_product [SLOTS];
    int unsigned                  live_count;
    int unsigned                  node_limit;
    int unsigned                  mismatches;
    node_reply_t                  replies_due [$];

    function new();
        live_count = 0;
        node_limit = cntbl_pkg::NODE_LIMIT_RST;
        mismatches = 0;
    endfunction

    function int unsigned slot_of(logic [cntbl_pkg::ADDR_W-1:0] a);
        for (int unsigned i = 0; i < live_count; i++)
        begin
            if (slot_addr[i] == a)
                return i;
        end
        return live_count;
    endfunction

    function void flag(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function void note_request(logic [cntbl_pkg::KIND_W-1:0] op,
                               logic [cntbl_pkg::ADDR_W-1:0] addr,
                               logic [cntbl_pkg::ID_W-1:0] id,
                               logic [cntbl_pkg::CODE_W-1:0] vendor,
                               logic [cntbl_pkg::CODE_W-1:0] product);
        node_reply_t r;
        int unsigned cap;
        int unsigned idx;
        r = '0;
        r.status = cntbl_pkg::STAT_NOTFOUND;
        cap = (node_limit < SLOTS) ? node_limit : SLOTS;
        case (op)
            cntbl_pkg::KIND_ADD:
            begin
                // room is checked before the duplicate search
                if (live_count >= cap)
                    r.status = cntbl_pkg::STAT_FULL;
                else if (slot_of(addr) < live_count)
                    r.status = cntbl_pkg::STAT_DUP;
                else
                begin
                    slot_addr[live_count]    = addr;
                    slot_vendor[live_count]  = vendor;
                    slot_product[live_count] = product;
                    r.id = cntbl_pkg::FID_W'(live_count);
                    live_count++;
                    r.status = cntbl_pkg::STAT_OK;
                end
            end
            cntbl_pkg::KIND_FIND_ID, cntbl_pkg::KIND_FIND_ADDR:
            begin
                if (op == cntbl_pkg::KIND_FIND_ID)
                    idx = id;
                else
                    idx = slot_of(addr);
                if (idx < live_count)
                begin
                    r.status  = cntbl_pkg::STAT_OK;
                    r.id      = cntbl_pkg::FID_W'(idx);
                    r.addr    = slot_addr[idx];
                    r.vendor  = slot_vendor[idx];
                    r.product = slot_product[idx];
                end
            end
            cntbl_pkg::KIND_REMOVE:
            begin
                if (id < live_count)
                begin
                    for (int unsigned i = id; i + 1 < live_count; i++)
                    begin
                        slot_addr[i]    = slot_addr[i + 1];
                        slot_vendor[i]  = slot_vendor[i + 1];
                        slot_product[i] = slot_product[i + 1];
                    end
                    live_count--;
                    r.status = cntbl_pkg::STAT_OK;
                end
            end
            cntbl_pkg::KIND_CLEAR:
            begin
                live_count = 0;
                r.status = cntbl_pkg::STAT_OK;
            end
            default:
            begin
            end
        endcase
        r.count = cntbl_pkg::CNT_OUT_W'(live_count);
        replies_due.push_back(r);
    endfunction

    function void check_reply(node_reply_t got);
        node_reply_t want;
        if (replies_due.size() == 0)
        begin
            flag($sformatf("reply beat with none due: st=%0d id=%0d cnt=%0d",
                           got.status, got.id, got.count));
            return;
        end
        want = replies_due.pop_front();
        if (got !== want)
            flag($sformatf({"reply mismatch: exp st=%0d id=%0d addr=%0d ven=%h prod=%h",
                            " cnt=%0d | got st=%0d id=%0d addr=%0d ven=%h prod=%h cnt=%0d"},
                           want.status, want.id, want.addr, want.vendor, want.product,
                           want.count, got.status, got.id, got.addr, got.vendor,
                           got.product, got.count));
    endfunction
endclass

module compacting_node_table_core_tb;

    localparam int TABLE_DEPTH  = 16;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;

    localparam logic [cntbl_pkg::KIND_W-1:0] KIND_UNUSED_FIRST = 3'd5;
    localparam logic [cntbl_pkg::KIND_W-1:0] KIND_UNUSED_LAST  = 3'd7;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_ready;
    logic [2:0]  kind         = '0;
    logic [6:0]  address      = '0;
    logic [7:0]  node_id      = '0;
    logic [15:0] vendor_code  = '0;
    logic [15:0] product_code = '0;
    logic        out_valid;
    logic        out_ready    = 1'b1;
    logic [1:0]  status;
    logic [3:0]  found_id;
    logic [6:0]  found_address;
    logic [15:0] found_vendor;
    logic [15:0] found_product;
    logic [4:0]  entry_count;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data     = '0;

    node_table_model #(TABLE_DEPTH) table_model;

    int unsigned gap_max     = 5;
    int unsigned stall_max   = 5;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    bit          valid_up    = 1'b0;

    compacting_node_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .address      (address),
        .node_id      (node_id),
        .vendor_code  (vendor_code),
        .product_code (product_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .found_id     (found_id),
        .found_address(found_address),
        .found_vendor (found_vendor),
        .found_product(found_product),
        .entry_count  (entry_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // reply side: check each beat, then hold ready low for a random stall
    always @(posedge clk)
    begin
        int unsigned hold;
        if (rst_n && out_valid && out_ready)
        begin
            table_model.check_reply('{status, found_id, found_address, found_vendor,
                                      found_product, entry_count});
            hold = $urandom_range(0, stall_max);
            if (hold > 0)
            begin
                out_ready  <= 1'b0;
                stall_left = hold;
            end
        end
        else if (!out_ready)
        begin
            stall_left--;
            if (stall_left == 0)
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [2:0] k, input logic [6:0] a,
                             input logic [7:0] id, input logic [15:0] v,
                             input logic [15:0] p);
        int unsigned gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0)
        begin
            if (valid_up)
                in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        address      <= a;
        node_id      <= id;
        vendor_code  <= v;
        product_code <= p;
        valid_up     = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        table_model.note_request(k, a, id, v, p);
    endtask

    task automatic drain_replies();
        if (valid_up)
            in_valid <= 1'b0;
        valid_up = 1'b0;
        while (table_model.replies_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [4:0] lim);
        drain_replies();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        table_model.node_limit = lim;
    endtask

    // mostly addresses from a small window so adds collide and finds hit
    task automatic send_random_op(input logic [6:0] base);
        logic [2:0]  k;
        logic [6:0]  a;
        logic [7:0]  id;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            k = cntbl_pkg::KIND_ADD;
        else if (pick < 63)
            k = cntbl_pkg::KIND_FIND_ID;
        else if (pick < 81)
            k = cntbl_pkg::KIND_FIND_ADDR;
        else if (pick < 93)
            k = cntbl_pkg::KIND_REMOVE;
        else if (pick < 95)
            k = cntbl_pkg::KIND_CLEAR;
        else
            k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
        if ($urandom_range(0, 4) == 0)
            a = 7'($urandom);
        else
            a = base + 7'($urandom_range(0, 23));
        if ($urandom_range(0, 6) == 0)
            id = 8'($urandom);
        else
            id = 8'($urandom_range(0, TABLE_DEPTH));
        send_item(k, a, id, 16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        int unsigned ph;
        int unsigned n;
        logic [6:0]  base;
        logic [4:0]  limits [10];
        limits = '{5'd31, 5'd0, 5'd16, 5'd1, 5'd5, 5'd2, 5'd16, 5'd15, 5'd31, 5'd9};
        table_model = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table
        send_item(cntbl_pkg::KIND_FIND_ID, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_REMOVE, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_FIND_ADDR, 7'd127, 8'd0, 16'h0000, 16'h0000);
        send_item(KIND_UNUSED_LAST, 7'd127, 8'd255, 16'hFFFF, 16'hFFFF);
        // extremes, duplicate, finds, remove with renumbering
        send_item(cntbl_pkg::KIND_ADD, 7'd127, 8'd0, 16'hFFFF, 16'h0000);
        send_item(cntbl_pkg::KIND_ADD, 7'd0, 8'd0, 16'h0000, 16'hFFFF);
        send_item(cntbl_pkg::KIND_ADD, 7'd127, 8'd0, 16'h1234, 16'h5678);
        send_item(cntbl_pkg::KIND_FIND_ADDR, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_FIND_ID, 7'd0, 8'd1, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_FIND_ID, 7'd0, 8'd255, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_REMOVE, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_FIND_ID, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_FIND_ADDR, 7'd127, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_REMOVE, 7'd0, 8'd255, 16'h0000, 16'h0000);
        send_item(KIND_UNUSED_FIRST, 7'd5, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_CLEAR, 7'd0, 8'd0, 16'h0000, 16'h0000);
        // full table wins over duplicate
        write_limit(5'd1);
        send_item(cntbl_pkg::KIND_ADD, 7'd5, 8'd0, 16'hAAAA, 16'h5555);
        send_item(cntbl_pkg::KIND_ADD, 7'd5, 8'd0, 16'hAAAA, 16'h5555);
        send_item(cntbl_pkg::KIND_ADD, 7'd6, 8'd0, 16'h0001, 16'h0002);
        // limit zero
        write_limit(5'd0);
        send_item(cntbl_pkg::KIND_FIND_ID, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_REMOVE, 7'd0, 8'd0, 16'h0000, 16'h0000);
        send_item(cntbl_pkg::KIND_ADD, 7'd9, 8'd0, 16'h0003, 16'h0004);

        for (ph = 0; ph < 10; ph++)
        begin
            write_limit(limits[ph]);
            gap_max   = (ph % 3 == 2) ? 0 : 5;
            stall_max = gap_max;
            base      = 7'($urandom);
            for (n = 0; n < 100; n++)
            begin
                if (n == 50)
                    drain_replies();
                send_random_op(base);
            end
        end

        drain_replies();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (table_model.mismatches == 0 && table_model.replies_due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
hdl/cntbl_pkg.sv
hdl/cntbl_cell.sv
hdl/compacting_node_table_core.sv
hdl/cntbl_checker.sv
tb/compacting_node_table_core_tb.sv
